### src/tsvf_pkg.sv
// shared constants and types for the trapezoidal state variable filter
`default_nettype none

package tsvf_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int STATE_WIDTH    = 32;
  localparam int COEF_WIDTH     = 32;

  localparam int OPND_WIDTH   = STATE_WIDTH + 1;
  localparam int PROD_WIDTH   = COEF_WIDTH + OPND_WIDTH;
  localparam int SCALED_WIDTH = PROD_WIDTH - COEF_FRAC_BITS;
  localparam int CAP_EXP      = 60;
  localparam int EXT_WIDTH    = (SCALED_WIDTH > CAP_EXP + 1) ? SCALED_WIDTH : CAP_EXP + 1;
  localparam int TERM_WIDTH   = EXT_WIDTH + 1;
  localparam int ACC_WIDTH    = TERM_WIDTH + 2;
  localparam int CNT_WIDTH    = $clog2(OPND_WIDTH + 1);

  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A1   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A2   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A3   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIX_INPUT = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIX_BAND  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIX_LOW   = 3'd5;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a1;
    logic signed [COEF_WIDTH-1:0] coef_a2;
    logic signed [COEF_WIDTH-1:0] coef_a3;
    logic signed [COEF_WIDTH-1:0] mix_input;
    logic signed [COEF_WIDTH-1:0] mix_band;
    logic signed [COEF_WIDTH-1:0] mix_low;
  } coef_set_t;

  typedef struct packed {
    logic                         start;
    logic signed [COEF_WIDTH-1:0] coef;
    logic signed [OPND_WIDTH-1:0] opnd;
  } mul_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [TERM_WIDTH-1:0] term;
  } mul_rsp_t;

endpackage

`default_nettype wire

### src/tsvf_in_if.sv
// input sample channel
`default_nettype none

interface tsvf_in_if import tsvf_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### src/tsvf_out_if.sv
// filtered sample channel
`default_nettype none

interface tsvf_out_if import tsvf_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### src/tsvf_cfg_regs.sv
// coefficient and mix register file
`default_nettype none

module tsvf_cfg_regs import tsvf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]      cfg_data,
  output coef_set_t                       coefs
);

  localparam logic signed [COEF_WIDTH-1:0] UNITY = COEF_WIDTH'(1) << COEF_FRAC_BITS;

  coef_set_t coefs_r, coefs_nxt;

  always_comb begin
    coefs_nxt = coefs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A1:   coefs_nxt.coef_a1   = cfg_data;
        REG_COEF_A2:   coefs_nxt.coef_a2   = cfg_data;
        REG_COEF_A3:   coefs_nxt.coef_a3   = cfg_data;
        REG_MIX_INPUT: coefs_nxt.mix_input = cfg_data;
        REG_MIX_BAND:  coefs_nxt.mix_band  = cfg_data;
        REG_MIX_LOW:   coefs_nxt.mix_low   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.coef_a1   <= UNITY;
      coefs_r.coef_a2   <= '0;
      coefs_r.coef_a3   <= '0;
      coefs_r.mix_input <= '0;
      coefs_r.mix_band  <= '0;
      coefs_r.mix_low   <= '0;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  assign coefs = coefs_r;

endmodule

`default_nettype wire

### src/tsvf_serial_mul.sv
// bit-serial shift-add coefficient multiplier with rounding and magnitude cap
`default_nettype none

module tsvf_serial_mul import tsvf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  mul_req_t  req,
  output mul_rsp_t  rsp
);

  localparam logic [COEF_WIDTH-1:0] HALF    = COEF_WIDTH'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [EXT_WIDTH-1:0]  CAP_VAL = EXT_WIDTH'(1) << CAP_EXP;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [COEF_WIDTH-1:0] m_r, m_nxt;
  logic [COEF_WIDTH-1:0] hi_r, hi_nxt;
  logic [OPND_WIDTH-1:0] lo_r, lo_nxt;

  logic [COEF_WIDTH:0]     step_sum;
  logic [PROD_WIDTH-1:0]   prod;
  logic [SCALED_WIDTH-1:0] scaled;
  logic [EXT_WIDTH-1:0]    scaled_ext;
  logic [EXT_WIDTH-1:0]    capped;
  logic signed [TERM_WIDTH-1:0] mag_term;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    m_nxt    = m_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    step_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, m_r} : '0);
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_WIDTH'(OPND_WIDTH - 1);
      neg_nxt  = req.coef[COEF_WIDTH-1] ^ req.opnd[OPND_WIDTH-1];
      m_nxt    = req.coef[COEF_WIDTH-1] ? COEF_WIDTH'(-req.coef) : COEF_WIDTH'(req.coef);
      lo_nxt   = req.opnd[OPND_WIDTH-1] ? OPND_WIDTH'(-req.opnd) : OPND_WIDTH'(req.opnd);
      // preloaded half lsb gives round to nearest on the magnitude
      hi_nxt   = HALF;
    end else if (busy_r) begin
      hi_nxt = step_sum[COEF_WIDTH:1];
      lo_nxt = {step_sum[0], lo_r[OPND_WIDTH-1:1]};
      cnt_nxt = cnt_r - CNT_WIDTH'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    m_r   <= m_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
  end

  always_comb begin
    prod       = {hi_r, lo_r};
    scaled     = prod[PROD_WIDTH-1:COEF_FRAC_BITS];
    scaled_ext = EXT_WIDTH'(scaled);
    capped     = (scaled_ext > CAP_VAL) ? CAP_VAL : scaled_ext;
    mag_term   = signed'({1'b0, capped});
    rsp.done   = done_r;
    rsp.term   = neg_r ? -mag_term : mag_term;
  end

endmodule

`default_nettype wire

### src/trapezoidal_state_variable_filter_core.sv
// trapezoidal state variable filter top level
`default_nettype none

// Takes one signed Q1.23 sample per item and returns one filtered, saturated
// sample. The seven coefficient products of an item share one bit-serial
// multiplier that consumes one operand bit per cycle, so a new item can be
// taken only once the current item's result is in the output register.
// in_ch.ready is high only while the block is between items; a finished
// result sits in the output register and does not hold off the next item.
// Coefficients and mix weights must be written through the cfg port only
// between items; the block itself does not enforce this. Writes to unused
// indexes are dropped.

module trapezoidal_state_variable_filter_core import tsvf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]      cfg_data,
  tsvf_in_if.sink                         in_ch,
  tsvf_out_if.source                      out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [2:0] OP_A1_IC1 = 3'd0;
  localparam logic [2:0] OP_A2_V3  = 3'd1;
  localparam logic [2:0] OP_A2_IC1 = 3'd2;
  localparam logic [2:0] OP_A3_V3  = 3'd3;
  localparam logic [2:0] OP_M0_V0  = 3'd4;
  localparam logic [2:0] OP_M1_V1  = 3'd5;
  localparam logic [2:0] OP_M2_V2  = 3'd6;

  localparam logic signed [ACC_WIDTH-1:0] ST_MAX =
    {{(ACC_WIDTH-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_WIDTH-1:0] SMP_MAX =
    {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] SMP_MIN = ~SMP_MAX;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [ACC_WIDTH-1:0] x);
    logic signed [ACC_WIDTH-1:0] y;
    y = (x > ST_MAX) ? ST_MAX : ((x < ST_MIN) ? ST_MIN : x);
    return y[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACC_WIDTH-1:0] x);
    logic signed [ACC_WIDTH-1:0] y;
    y = (x > SMP_MAX) ? SMP_MAX : ((x < SMP_MIN) ? SMP_MIN : x);
    return y[SAMPLE_WIDTH-1:0];
  endfunction

  coef_set_t coefs;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;

  logic [1:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic signed [STATE_WIDTH-1:0]  ic1_r, ic1_nxt;
  logic signed [STATE_WIDTH-1:0]  ic2_r, ic2_nxt;
  logic signed [STATE_WIDTH-1:0]  v1_r, v1_nxt;
  logic signed [STATE_WIDTH-1:0]  v2_r, v2_nxt;
  logic signed [SAMPLE_WIDTH-1:0] v0_r, v0_nxt;
  logic signed [OPND_WIDTH-1:0]   v3_r, v3_nxt;
  logic signed [ACC_WIDTH-1:0]    acc_r, acc_nxt;

  tsvf_cfg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  tsvf_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    mul_req.start = (state_r == ST_LOAD);
    case (op_r)
      OP_A1_IC1: begin
        mul_req.coef = coefs.coef_a1;
        mul_req.opnd = OPND_WIDTH'(ic1_r);
      end
      OP_A2_V3: begin
        mul_req.coef = coefs.coef_a2;
        mul_req.opnd = v3_r;
      end
      OP_A2_IC1: begin
        mul_req.coef = coefs.coef_a2;
        mul_req.opnd = OPND_WIDTH'(ic1_r);
      end
      OP_A3_V3: begin
        mul_req.coef = coefs.coef_a3;
        mul_req.opnd = v3_r;
      end
      OP_M0_V0: begin
        mul_req.coef = coefs.mix_input;
        mul_req.opnd = OPND_WIDTH'(v0_r);
      end
      OP_M1_V1: begin
        mul_req.coef = coefs.mix_band;
        mul_req.opnd = OPND_WIDTH'(v1_r);
      end
      OP_M2_V2: begin
        mul_req.coef = coefs.mix_low;
        mul_req.opnd = OPND_WIDTH'(v2_r);
      end
      default: begin
        mul_req.coef = '0;
        mul_req.opnd = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    ic1_nxt        = ic1_r;
    ic2_nxt        = ic2_r;
    v0_nxt         = v0_r;
    v1_nxt         = v1_r;
    v2_nxt         = v2_r;
    v3_nxt         = v3_r;
    acc_nxt        = acc_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          v0_nxt    = in_ch.sample_in;
          v3_nxt    = OPND_WIDTH'(in_ch.sample_in) - OPND_WIDTH'(ic2_r);
          op_nxt    = OP_A1_IC1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        case (op_r)
          OP_A1_IC1: acc_nxt = '0;
          OP_A2_IC1: begin
            v1_nxt  = sat_state(acc_r);
            acc_nxt = ACC_WIDTH'(ic2_r);
          end
          OP_M0_V0: begin
            v2_nxt  = sat_state(acc_r);
            acc_nxt = '0;
          end
          default: ;
        endcase
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          acc_nxt = acc_r + ACC_WIDTH'(mul_rsp.term);
          if (op_r == OP_M2_V2) begin
            state_nxt = ST_FIN;
          end else begin
            op_nxt    = op_r + 3'd1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_sample_nxt = sat_sample(acc_r);
          out_valid_nxt  = 1'b1;
          ic1_nxt = sat_state(ACC_WIDTH'(v1_r) + ACC_WIDTH'(v1_r) - ACC_WIDTH'(ic1_r));
          ic2_nxt = sat_state(ACC_WIDTH'(v2_r) + ACC_WIDTH'(v2_r) - ACC_WIDTH'(ic2_r));
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_A1_IC1;
      out_valid_r <= 1'b0;
      ic1_r       <= '0;
      ic2_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      ic1_r       <= ic1_nxt;
      ic2_r       <= ic2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    v0_r         <= v0_nxt;
    v1_r         <= v1_nxt;
    v2_r         <= v2_nxt;
    v3_r         <= v3_nxt;
    acc_r        <= acc_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

endmodule

`default_nettype wire

### src/tsvf_checker.sv
// port-level checks for the filter core and their binding
`default_nettype none

module tsvf_checker import tsvf_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] out_sample
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared right after an item was taken");

endmodule

bind trapezoidal_state_variable_filter_core tsvf_checker u_tsvf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out)
);

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for the trapezoidal state variable filter core
module tb_top;
  import tsvf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = 32'sh8000_0000;

  typedef enum int {LOWPASS, BANDPASS, HIGHPASS, NOTCH, PEAK, ALLPASS} response_t;

  class filter_scoreboard;
    typedef logic signed [95:0] wide_t;

    coef_set_t coefs;
    logic signed [STATE_WIDTH-1:0] integ_one;
    logic signed [STATE_WIDTH-1:0] integ_two;
    logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
    int mismatches;
    int samples_in;
    int samples_out;
    int railed;

    function new();
      coefs = '0;
      coefs.coef_a1 = COEF_ONE;
      integ_one = '0;
      integ_two = '0;
      mismatches = 0;
      samples_in = 0;
      samples_out = 0;
      railed = 0;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [COEF_WIDTH-1:0] data);
      case (idx)
        REG_COEF_A1:   coefs.coef_a1 = data;
        REG_COEF_A2:   coefs.coef_a2 = data;
        REG_COEF_A3:   coefs.coef_a3 = data;
        REG_MIX_INPUT: coefs.mix_input = data;
        REG_MIX_BAND:  coefs.mix_band = data;
        REG_MIX_LOW:   coefs.mix_low = data;
        default: ;
      endcase
    endfunction

    // coefficient times value, rounded half away from zero, magnitude capped
    function wide_t scaled_product(logic signed [COEF_WIDTH-1:0] c, wide_t x);
      wide_t cw;
      wide_t mc;
      wide_t mx;
      wide_t r;
      logic [191:0] prod;
      cw = wide_t'(c);
      mc = (cw < 0) ? -cw : cw;
      mx = (x < 0) ? -x : x;
      prod = $unsigned(mc) * $unsigned(mx) + (192'd1 << (COEF_FRAC_BITS - 1));
      prod = prod >> COEF_FRAC_BITS;
      if (prod > (192'd1 << CAP_EXP)) prod = 192'd1 << CAP_EXP;
      r = prod[95:0];
      return ((cw < 0) != (x < 0)) ? -r : r;
    endfunction

    function wide_t clamp(wide_t v, int width);
      wide_t top;
      wide_t bottom;
      top = wide_t'(1);
      top = (top <<< (width - 1)) - 1;
      bottom = -top - 1;
      if (v > top) return top;
      if (v < bottom) return bottom;
      return v;
    endfunction

    function void note_sample(logic signed [SAMPLE_WIDTH-1:0] s);
      wide_t v0;
      wide_t ic1;
      wide_t ic2;
      wide_t v1;
      wide_t v2;
      wide_t v3;
      wide_t y;
      wide_t next_one;
      wide_t next_two;
      v0 = wide_t'(s);
      ic1 = wide_t'(integ_one);
      ic2 = wide_t'(integ_two);
      v3 = v0 - ic2;
      v1 = clamp(scaled_product(coefs.coef_a1, ic1) + scaled_product(coefs.coef_a2, v3),
                 STATE_WIDTH);
      v2 = clamp(ic2 + scaled_product(coefs.coef_a2, ic1) + scaled_product(coefs.coef_a3, v3),
                 STATE_WIDTH);
      next_one = clamp((v1 <<< 1) - ic1, STATE_WIDTH);
      next_two = clamp((v2 <<< 1) - ic2, STATE_WIDTH);
      integ_one = next_one[STATE_WIDTH-1:0];
      integ_two = next_two[STATE_WIDTH-1:0];
      y = scaled_product(coefs.mix_input, v0) + scaled_product(coefs.mix_band, v1)
          + scaled_product(coefs.mix_low, v2);
      y = clamp(y, SAMPLE_WIDTH);
      if (y == SAMPLE_MAX || y == SAMPLE_MIN) railed++;
      expected_samples.push_back(y[SAMPLE_WIDTH-1:0]);
      samples_in++;
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_sample(logic signed [SAMPLE_WIDTH-1:0] got);
      logic signed [SAMPLE_WIDTH-1:0] want;
      samples_out++;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no item pending", got));
      end else begin
        want = expected_samples.pop_front();
        if (got !== want)
          report_mismatch($sformatf("item %0d: sample_out %0d, expected %0d",
                                    samples_out, got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [COEF_WIDTH-1:0] cfg_data;
  bit idle_on;
  int hold_cycles;
  int settings_used;

  tsvf_in_if in_ch();
  tsvf_out_if out_ch();

  filter_scoreboard sb = new();

  trapezoidal_state_variable_filter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample_out);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample_in);
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || !in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [COEF_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_coefs(coef_set_t c);
    drain_results();
    write_reg(REG_COEF_A1, c.coef_a1);
    write_reg(REG_COEF_A2, c.coef_a2);
    write_reg(REG_COEF_A3, c.coef_a3);
    write_reg(REG_MIX_INPUT, c.mix_input);
    write_reg(REG_MIX_BAND, c.mix_band);
    write_reg(REG_MIX_LOW, c.mix_low);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [COEF_WIDTH-1:0] q_format(real x);
    return $rtoi(x * (2.0 ** COEF_FRAC_BITS));
  endfunction

  function automatic coef_set_t random_coefs();
    coef_set_t c;
    logic [5:0][COEF_WIDTH-1:0] raw;
    real g;
    real k;
    real a1;
    response_t shape;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int i = 0; i < 6; i++) raw[i] = $urandom;
        c = raw;
      end
      2: begin
        for (int i = 0; i < 6; i++) begin
          case ($urandom_range(0, 5))
            0: raw[i] = COEF_MAX;
            1: raw[i] = COEF_MIN;
            2: raw[i] = '0;
            3: raw[i] = COEF_ONE;
            4: raw[i] = -COEF_ONE;
            default: raw[i] = $urandom;
          endcase
        end
        c = raw;
      end
      default: begin
        g = $urandom_range(1, 3000) / 1000.0;
        k = $urandom_range(50, 2000) / 1000.0;
        a1 = 1.0 / (1.0 + g * (g + k));
        c.coef_a1 = q_format(a1);
        c.coef_a2 = q_format(g * a1);
        c.coef_a3 = q_format(g * g * a1);
        shape = response_t'($urandom_range(0, 5));
        c.mix_input = (shape == LOWPASS || shape == BANDPASS) ? '0 : COEF_ONE;
        case (shape)
          LOWPASS:  begin c.mix_band = '0;             c.mix_low = COEF_ONE;       end
          BANDPASS: begin c.mix_band = COEF_ONE;       c.mix_low = '0;             end
          HIGHPASS: begin c.mix_band = q_format(-k);   c.mix_low = -COEF_ONE;      end
          NOTCH:    begin c.mix_band = q_format(-k);   c.mix_low = '0;             end
          PEAK:     begin c.mix_band = q_format(-k);   c.mix_low = q_format(-2.0); end
          default:  begin c.mix_band = q_format(-2.0 * k); c.mix_low = '0;         end
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(
      logic signed [SAMPLE_WIDTH-1:0] prev);
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return prev;
      4, 5: return SAMPLE_WIDTH'($urandom_range(0, 4096) - 2048);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    #(40_000_000);
    $display("trapezoidal_state_variable_filter_core: mismatch");
    $finish;
  end

  initial begin
    logic signed [SAMPLE_WIDTH-1:0] probes [$];
    logic signed [SAMPLE_WIDTH-1:0] last;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COEF_A1;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    idle_on = 1'b1;
    hold_cycles = 0;
    settings_used = 1;
    last = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset weights keep the output silent
    probes = {SAMPLE_MAX, SAMPLE_MIN, 24'sd1};
    foreach (probes[i]) send_sample(probes[i]);

    // moderate lowpass mixed with input and bandpass, steps at both rails
    load_coefs('{32'sd9586981, 32'sd4793490, 32'sd2396745,
                 COEF_ONE, -COEF_ONE, 32'sd8388608});
    probes = {SAMPLE_MAX, SAMPLE_MIN, 24'sd0, -24'sd1, 24'sd1,
              SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN};
    foreach (probes[i]) send_sample(probes[i]);

    // extreme coefficients drive nodes, integrators and output into saturation
    load_coefs('{COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX});
    probes = {SAMPLE_MAX, SAMPLE_MIN, 24'sd1, -24'sd1, 24'sd0, SAMPLE_MAX};
    foreach (probes[i]) send_sample(probes[i]);

    // all-zero coefficients
    load_coefs('0);
    probes = {SAMPLE_MIN, SAMPLE_MAX};
    foreach (probes[i]) send_sample(probes[i]);

    for (int p = 0; p < 16; p++) begin
      load_coefs(random_coefs());
      idle_on = (p < 13);
      if (p == 3) hold_cycles = 3000;
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && p % 4 == 1) drain_results();
        last = pick_sample(last);
        send_sample(last);
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    $display("%0d samples filtered under %0d coefficient settings, %0d results at a rail",
             sb.samples_in, settings_used, sb.railed);
    $display("stalls and gaps on both channels, one long output hold-off, drained pauses");
    if (sb.mismatches == 0) begin
      $display("trapezoidal_state_variable_filter_core: match");
    end else begin
      $display("trapezoidal_state_variable_filter_core: mismatch");
    end
    $finish;
  end
endmodule
